### rtl/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg: shared types and constants of the escape decoder
// Beat types for both channels, the decoded command passed from the front to
// the back, and the depth of the command queue between them.
// ----------------------------------------------------------------------------
package ced_pkg;

    // Depth of the command queue. It must be a power of two.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // One or two output beats produced by one input beat.
    typedef struct packed {
        logic      two;
        t_out_beat first;
        t_out_beat second;
    } t_cmd;

endpackage

### rtl/c_escape_decoder.sv
// ----------------------------------------------------------------------------
// c_escape_decoder: streaming C-style backslash escape decoder
// Top level joining the classifier, the command queue and the output stage.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle while the four-entry command queue has room;
// its readiness depends only on that queue, not on the output side. Each byte
// yields zero, one or two decoded beats, and the output stage sends one beat
// per cycle while i_out_ready is high, so a byte that flushes a pending escape
// before itself costs two output beats. Decoded bytes appear no earlier than
// the cycle after their input byte is taken.
module c_escape_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ced_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ced_pkg::t_out_beat o_out_data
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    ced_pkg::t_cmd cmd;
    ced_pkg::t_cmd head;

    ced_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    ced_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    ced_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/ced_front.sv
// ----------------------------------------------------------------------------
// ced_front: input stage and escape classifier
// Accepts raw bytes, tracks the escape mode and gathered digit value, and
// turns each byte into a command of zero, one or two output beats.
// ----------------------------------------------------------------------------
module ced_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ced_pkg::t_in_beat i_in_data,
    input  logic              i_full,
    output logic              o_push,
    output ced_pkg::t_cmd     o_cmd
);

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_7    = 8'h37;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_HEX0  = 3'd2,
        MODE_HEX1  = 3'd3,
        MODE_OCT1  = 3'd4,
        MODE_OCT2  = 3'd5
    } t_mode;

    t_mode       r_mode;
    t_mode       n_mode;
    logic [7:0]  r_digit;
    logic [7:0]  n_digit;
    logic [1:0]  cnt;
    logic        accept;
    logic [7:0]  b;
    logic        last;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        oct_ok;
    logic        named_ok;
    logic [7:0]  named_val;
    logic        plain_esc;

    assign b      = i_in_data.in_byte;
    assign last   = i_in_data.in_last;
    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = !i_full;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            hex_val = 4'(b - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        named_ok  = 1'b1;
        named_val = 8'd0;
        case (b)
            8'h6E:     named_val = 8'd10;
            8'h72:     named_val = 8'd13;
            8'h61:     named_val = 8'd7;
            8'h74:     named_val = 8'd9;
            8'h76:     named_val = 8'd11;
            8'h62:     named_val = 8'd8;
            8'h66:     named_val = 8'd12;
            BACKSLASH: named_val = BACKSLASH;
            default:   named_ok  = 1'b0;
        endcase
    end

    assign oct_ok    = (b >= CHAR_0) && (b <= CHAR_7);
    assign plain_esc = (b == BACKSLASH) && !last;

    always_comb begin
        n_mode  = r_mode;
        n_digit = r_digit;
        cnt     = 2'd0;
        o_cmd   = '0;
        case (r_mode)
            MODE_ESC: begin
                if (named_ok) begin
                    cnt    = 2'd1;
                    o_cmd.first = '{out_byte: named_val, out_last: last};
                    n_mode = MODE_PLAIN;
                end else if (b == CHAR_X) begin
                    if (last) begin
                        cnt    = 2'd1;
                        o_cmd.first = '{out_byte: b, out_last: last};
                        n_mode = MODE_PLAIN;
                    end else begin
                        n_mode = MODE_HEX0;
                    end
                end else if (oct_ok) begin
                    n_digit = {5'd0, b[2:0]};
                    if (last) begin
                        cnt    = 2'd1;
                        o_cmd.first = '{out_byte: {5'd0, b[2:0]}, out_last: last};
                        n_mode = MODE_PLAIN;
                    end else begin
                        n_mode = MODE_OCT1;
                    end
                end else begin
                    cnt    = 2'd1;
                    o_cmd.first = '{out_byte: b, out_last: last};
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_HEX0, MODE_HEX1, MODE_OCT1, MODE_OCT2: begin
                if ((r_mode == MODE_HEX0) && hex_ok) begin
                    n_digit = {4'd0, hex_val};
                    if (last) begin
                        cnt    = 2'd1;
                        o_cmd.first = '{out_byte: {4'd0, hex_val}, out_last: last};
                        n_mode = MODE_PLAIN;
                    end else begin
                        n_mode = MODE_HEX1;
                    end
                end else if ((r_mode == MODE_HEX1) && hex_ok) begin
                    cnt    = 2'd1;
                    o_cmd.first = '{out_byte: {r_digit[3:0], hex_val}, out_last: last};
                    n_mode = MODE_PLAIN;
                end else if ((r_mode == MODE_OCT1) && oct_ok) begin
                    n_digit = {r_digit[4:0], b[2:0]};
                    if (last) begin
                        cnt    = 2'd1;
                        o_cmd.first = '{out_byte: {r_digit[4:0], b[2:0]},
                                        out_last: last};
                        n_mode = MODE_PLAIN;
                    end else begin
                        n_mode = MODE_OCT2;
                    end
                end else if ((r_mode == MODE_OCT2) && oct_ok) begin
                    cnt    = 2'd1;
                    o_cmd.first = '{out_byte: {r_digit[4:0], b[2:0]}, out_last: last};
                    n_mode = MODE_PLAIN;
                end else begin
                    // The pending escape is flushed before this byte is handled as text.
                    o_cmd.first = '{out_byte: (r_mode == MODE_HEX0) ? CHAR_X : r_digit,
                                    out_last: 1'b0};
                    if (plain_esc) begin
                        cnt    = 2'd1;
                        n_mode = MODE_ESC;
                    end else begin
                        cnt    = 2'd2;
                        o_cmd.second = '{out_byte: b, out_last: last};
                        n_mode = MODE_PLAIN;
                    end
                end
            end
            default: begin
                if (plain_esc) begin
                    n_mode = MODE_ESC;
                end else begin
                    cnt    = 2'd1;
                    o_cmd.first = '{out_byte: b, out_last: last};
                    n_mode = MODE_PLAIN;
                end
            end
        endcase
        if (n_mode == MODE_PLAIN || last) begin
            n_mode  = MODE_PLAIN;
            n_digit = 8'd0;
        end
        o_cmd.two = (cnt == 2'd2);
    end

    assign o_push = accept && (cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLAIN;
            r_digit <= 8'd0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_digit <= n_digit;
        end
    end

endmodule

### rtl/ced_fifo.sv
// ----------------------------------------------------------------------------
// ced_fifo: command queue
// A small register queue that decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
module ced_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ced_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ced_pkg::t_cmd o_head,
    output logic          o_empty,
    output logic          o_full
);

    ced_pkg::t_cmd                r_mem [ced_pkg::QUEUE_DEPTH];
    logic [ced_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [ced_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [ced_pkg::QPTR_W:0]     r_count;
    logic [ced_pkg::QPTR_W:0]     n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (ced_pkg::QPTR_W + 1)'(ced_pkg::QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (ced_pkg::QPTR_W + 1)'(ced_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full || (r_wr_ptr - r_rd_ptr) == r_count[ced_pkg::QPTR_W-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/ced_back.sv
// ----------------------------------------------------------------------------
// ced_back: output sequencer
// Presents the beats of the command at the head of the queue, one per
// handshake, and releases the command after its final beat.
// ----------------------------------------------------------------------------
module ced_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ced_pkg::t_cmd      i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ced_pkg::t_out_beat o_out_data
);

    logic r_second;

    assign o_out_valid = !i_empty;
    assign o_out_data  = r_second ? i_head.second : i_head.first;
    assign o_pop       = o_out_valid && i_out_ready && (!i_head.two || r_second);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_second <= i_head.two && !r_second;
        end
    end

endmodule

### tb/escape_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_check_pkg: expected-result tracking for the escape decoder bench
// Holds a cycle-free model of the backslash escape decoder that turns each
// accepted input beat into the decoded beats it should cause, and a queue
// against which every beat leaving the block is compared field by field.
// ----------------------------------------------------------------------------
package escape_check_pkg;

    localparam logic [7:0] BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_7    = 8'h37;

    typedef enum logic [2:0] {
        ST_TEXT,
        ST_ESCAPE,
        ST_HEX_NONE,
        ST_HEX_ONE,
        ST_OCT_ONE,
        ST_OCT_TWO
    } t_decode_state;

    class t_escape_scoreboard;

        t_decode_state      state;
        logic [7:0]         digits;
        ced_pkg::t_out_beat decoded_q[$];
        int                 errors;

        function new();
            state  = ST_TEXT;
            digits = 8'h00;
            errors = 0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function bit is_octal(logic [7:0] b);
            return b >= CHAR_0 && b <= CHAR_7;
        endfunction

        // Bit 4 set means the byte is not a hex digit.
        function logic [4:0] hex_value(logic [7:0] b);
            if (b >= CHAR_0 && b <= 8'h39) begin
                return {1'b0, b[3:0]};
            end
            if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
                return {1'b0, b[3:0] + 4'd9};
            end
            return 5'h10;
        endfunction

        // Bit 8 set means the byte names no control character.
        function logic [8:0] control_byte(logic [7:0] b);
            case (b)
                "n":       return 9'd10;
                "r":       return 9'd13;
                "a":       return 9'd7;
                "t":       return 9'd9;
                "v":       return 9'd11;
                "b":       return 9'd8;
                "f":       return 9'd12;
                BACKSLASH: return {1'b0, BACKSLASH};
                default:   return 9'h100;
            endcase
        endfunction

        function void emit(logic [7:0] value, logic last);
            ced_pkg::t_out_beat beat;
            beat.out_byte = value;
            beat.out_last = last;
            decoded_q.push_back(beat);
        endfunction

        function void take_text(logic [7:0] b, logic last);
            if (b == BACKSLASH && !last) begin
                state = ST_ESCAPE;
            end else begin
                state = ST_TEXT;
                emit(b, last);
            end
        endfunction

        function void decode_byte(ced_pkg::t_in_beat beat);
            logic [7:0] b;
            logic       last;
            logic [4:0] hex;
            logic [8:0] ctl;
            b    = beat.in_byte;
            last = beat.in_last;
            hex  = hex_value(b);
            ctl  = control_byte(b);
            case (state)
                ST_ESCAPE: begin
                    if (!ctl[8]) begin
                        emit(ctl[7:0], last);
                        state = ST_TEXT;
                    end else if (b == CHAR_X) begin
                        if (last) begin
                            emit(b, last);
                            state = ST_TEXT;
                        end else begin
                            state = ST_HEX_NONE;
                        end
                    end else if (is_octal(b)) begin
                        digits = {5'b0, b[2:0]};
                        if (last) begin
                            emit(digits, last);
                            state = ST_TEXT;
                        end else begin
                            state = ST_OCT_ONE;
                        end
                    end else begin
                        emit(b, last);
                        state = ST_TEXT;
                    end
                end
                ST_HEX_NONE: begin
                    if (!hex[4]) begin
                        digits = {4'b0, hex[3:0]};
                        if (last) begin
                            emit(digits, last);
                            state = ST_TEXT;
                        end else begin
                            state = ST_HEX_ONE;
                        end
                    end else begin
                        emit(CHAR_X, 1'b0);
                        take_text(b, last);
                    end
                end
                ST_HEX_ONE: begin
                    if (!hex[4]) begin
                        emit({digits[3:0], hex[3:0]}, last);
                        state = ST_TEXT;
                    end else begin
                        emit(digits, 1'b0);
                        take_text(b, last);
                    end
                end
                ST_OCT_ONE: begin
                    if (is_octal(b)) begin
                        digits = {digits[4:0], 3'b0} + {5'b0, b[2:0]};
                        if (last) begin
                            emit(digits, last);
                            state = ST_TEXT;
                        end else begin
                            state = ST_OCT_TWO;
                        end
                    end else begin
                        emit(digits, 1'b0);
                        take_text(b, last);
                    end
                end
                ST_OCT_TWO: begin
                    if (is_octal(b)) begin
                        emit({digits[4:0], 3'b0} + {5'b0, b[2:0]}, last);
                        state = ST_TEXT;
                    end else begin
                        emit(digits, 1'b0);
                        take_text(b, last);
                    end
                end
                default: begin
                    take_text(b, last);
                end
            endcase
            if (state == ST_TEXT) begin
                digits = 8'h00;
            end
            if (last) begin
                state  = ST_TEXT;
                digits = 8'h00;
            end
        endfunction

        task report(input string what);
            $display("%0t ns: %s", $time, what);
            errors++;
        endtask

        task compare_decoded(input ced_pkg::t_out_beat got);
            ced_pkg::t_out_beat want;
            if (decoded_q.size() == 0) begin
                report($sformatf("unexpected beat byte=%02h last=%0b",
                                 got.out_byte, got.out_last));
            end else begin
                want = decoded_q.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    report($sformatf("out_byte is %02h, expected %02h",
                                     got.out_byte, want.out_byte));
                end
                if (got.out_last !== want.out_last) begin
                    report($sformatf("out_last is %0b, expected %0b (byte %02h)",
                                     got.out_last, want.out_last, want.out_byte));
                end
            end
        endtask

        task check_drained();
            if (decoded_q.size() != 0) begin
                report($sformatf("%0d decoded beats never arrived", decoded_q.size()));
            end
        endtask

    endclass

endpackage

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the C-style escape decoder
// Sends a short hand-written set of escape sequences, then about 1500 random
// beats of random bytes, text and escapes, some malformed, with random gaps on
// the input and random output stalls. Every decoded beat is checked in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_BEATS = 1500;
    localparam int unsigned CALM_FROM    = 1200;

    localparam logic [7:0] NAMED_ESC [8] = '{"n", "r", "a", "t", "v", "b", "f",
                                             escape_check_pkg::BACKSLASH};

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    ced_pkg::t_in_beat  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    ced_pkg::t_out_beat o_out_data;

    int unsigned idle_pct   = 10;
    int unsigned beats_sent = 0;

    escape_check_pkg::t_escape_scoreboard model = new();

    c_escape_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic send_beat(input logic [7:0] value, input logic last);
        ced_pkg::t_in_beat beat;
        beat.in_byte = value;
        beat.in_last = last;
        if ($urandom_range(1, 100) <= idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        model.decode_byte(beat);
        beats_sent++;
    endtask

    task automatic send_text(input string text, input bit ends_text);
        for (int i = 0; i < text.len(); i++) begin
            send_beat(text[i], ends_text && (i == text.len() - 1));
        end
    endtask

    function automatic logic [7:0] hex_char(int unsigned v);
        if (v < 10) begin
            return escape_check_pkg::CHAR_0 + 8'(v);
        end
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
    endfunction

    task automatic send_token();
        logic [7:0] seq[$];
        int unsigned count;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
            3: begin
                seq.push_back(escape_check_pkg::BACKSLASH);
                seq.push_back(NAMED_ESC[$urandom_range(0, 7)]);
            end
            4, 5: begin
                seq.push_back(escape_check_pkg::BACKSLASH);
                seq.push_back(escape_check_pkg::CHAR_X);
                count = $urandom_range(0, 2);
                repeat (count) seq.push_back(hex_char($urandom_range(0, 15)));
            end
            6, 7: begin
                seq.push_back(escape_check_pkg::BACKSLASH);
                count = $urandom_range(1, 3);
                repeat (count) begin
                    seq.push_back(escape_check_pkg::CHAR_0 + 8'($urandom_range(0, 7)));
                end
            end
            8: begin
                seq.push_back(escape_check_pkg::BACKSLASH);
                seq.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                count = $urandom_range(2, 5);
                repeat (count) seq.push_back(8'($urandom_range(32, 126)));
            end
        endcase
        foreach (seq[i]) begin
            send_beat(seq[i], $urandom_range(0, 24) == 0);
        end
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if ($urandom_range(1, 100) <= idle_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            model.compare_decoded(o_out_data);
        end
    end

    initial begin
        int unsigned segment_end;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("\\n\\xAf\\777\\12\\q", 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(escape_check_pkg::BACKSLASH, 1'b1);
        send_text("\\xg\\5", 1'b1);
        send_text("\\x", 1'b1);

        beats_sent  = 0;
        segment_end = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent >= CALM_FROM) begin
                idle_pct = 0;
            end else if (beats_sent >= segment_end) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
                segment_end = beats_sent + 200;
            end
            send_token();
        end
        send_beat(8'h41, 1'b1);
        i_in_valid <= 1'b0;

        while (model.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        model.check_drained();
        if (model.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
